@@ hw/rtl/circular_deque_rotate_swap_macros.svh @@
// Assertion macros shared by the deque RTL.
`ifndef CIRCULAR_DEQUE_ROTATE_SWAP_MACROS_SVH
`define CIRCULAR_DEQUE_ROTATE_SWAP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CDRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CDRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cdrs_pkg.sv @@
// Types and codes shared by the circular deque block.
`timescale 1ns / 1ps
`default_nettype none

package cdrs_pkg;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
		logic [9:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] front_value;
		logic [10:0]        entry_count;
		logic [1:0]         status;
	} rsp_t;

	localparam logic [2:0] OP_PUSH     = 3'd0;
	localparam logic [2:0] OP_DELETE   = 3'd1;
	localparam logic [2:0] OP_SWAP     = 3'd2;
	localparam logic [2:0] OP_ROT_FWD  = 3'd3;
	localparam logic [2:0] OP_ROT_BACK = 3'd4;
	localparam logic [2:0] OP_CLEAR    = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_DEL_RD,
		S_DEL_WR,
		S_SWAP_RD1,
		S_SWAP_RD2,
		S_SWAP_WR,
		S_ROTF_WR,
		S_ROTF_ADV,
		S_ROTB_RD,
		S_ROTB_WR,
		S_FRONT_RD,
		S_FRONT_WAIT
	} seq_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/cdrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cdrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/circular_deque_rotate_swap.sv @@
// Circular deque with push, delete, swap, rotate and clear over a ring store.
//
// Usage: one request word on req_word (op, value, position) is taken when
// req_valid is high and req_stall is low. Each request gives exactly one
// response word on rsp_word (front_value, entry_count, status), offered with
// rsp_valid and taken when rsp_stall is low.
// The ring store has a single read port: every value moved is read and then
// written back, and the front value is read back last.
// The block holds one request at a time; req_stall is high while it works.
// The response sits in an output register, so the next request is taken
// while an earlier response still waits; if that response is still stalled
// when the next one is ready, the sequencer holds until it is taken.
// Reset empties the deque at once (count and front go to zero, no clearing
// pass); store contents are not cleared and never read before written.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_rotate_swap_macros.svh"

module circular_deque_rotate_swap #(
	parameter int DEPTH = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire cdrs_pkg::req_t req_word,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output cdrs_pkg::rsp_t      rsp_word
);

	import cdrs_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PW    = (CNT_W > 10) ? CNT_W : 10;
	localparam int SUM_W = CNT_W + 1;

	seq_state_t state_q, state_d;

	req_t             req_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] nslot_q;
	logic [CNT_W-1:0] rem_q;
	logic [31:0]      tmp_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// shared ring adder
	logic [IDX_W-1:0] ra_base;
	logic [CNT_W-1:0] ra_off;
	logic [SUM_W-1:0] ra_raw;
	logic [IDX_W-1:0] ra_sum;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [31:0]      ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [31:0]      ram_rdata;

	logic             empty;
	logic             full;
	logic             pos_bad;
	logic [CNT_W-1:0] pos_c;
	logic [CNT_W-1:0] rem_calc;
	logic             rsp_load;

	assign ra_raw = SUM_W'(ra_base) + SUM_W'(ra_off);
	assign ra_sum = (ra_raw >= SUM_W'(DEPTH)) ? IDX_W'(ra_raw - SUM_W'(DEPTH)) : IDX_W'(ra_raw);

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign pos_bad  = (PW'(req_q.position) >= PW'(count_q));
	assign pos_c    = CNT_W'(PW'(req_q.position));
	assign rem_calc = count_q - CNT_W'(1) - pos_c;
	assign rsp_load = (state_q == S_FRONT_WAIT) && (!rsp_valid_q || !rsp_stall);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	cdrs_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ra_base   = front_q;
		ra_off    = '0;
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_wdata = tmp_q;
		ram_raddr = front_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FRONT_RD;
				case (req_q.op)
					OP_PUSH: begin
						ra_off = CNT_W'(DEPTH - 1);
						if (!full) begin
							ram_we    = 1'b1;
							ram_waddr = ra_sum;
							ram_wdata = req_q.value;
						end
					end
					OP_DELETE: begin
						ra_off = pos_c;
						if (!empty && !pos_bad && rem_calc != '0) begin
							state_d = S_DEL_RD;
						end
					end
					OP_SWAP: begin
						if (!empty && count_q != CNT_W'(1)) begin
							state_d = S_SWAP_RD1;
						end
					end
					OP_ROT_FWD: begin
						if (!empty) begin
							state_d = S_ROTF_WR;
						end
					end
					OP_ROT_BACK: begin
						ra_off = CNT_W'(DEPTH - 1);
						if (!empty) begin
							state_d = S_ROTB_RD;
						end
					end
					default: begin
						state_d = S_FRONT_RD;
					end
				endcase
			end
			S_DEL_RD: begin
				ra_base   = slot_q;
				ra_off    = CNT_W'(1);
				ram_raddr = ra_sum;
				state_d   = S_DEL_WR;
			end
			S_DEL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = ram_rdata;
				state_d   = (rem_q == CNT_W'(1)) ? S_FRONT_RD : S_DEL_RD;
			end
			S_SWAP_RD1: begin
				ra_off    = CNT_W'(1);
				ram_raddr = ra_sum;
				state_d   = S_SWAP_RD2;
			end
			S_SWAP_RD2: begin
				ram_we    = 1'b1;
				ram_waddr = front_q;
				ram_wdata = ram_rdata;
				state_d   = S_SWAP_WR;
			end
			S_SWAP_WR: begin
				ra_off    = CNT_W'(1);
				ram_we    = 1'b1;
				ram_waddr = ra_sum;
				ram_wdata = tmp_q;
				state_d   = S_FRONT_RD;
			end
			S_ROTF_WR: begin
				// old front value lands just past the back
				ra_off    = count_q;
				ram_we    = 1'b1;
				ram_waddr = ra_sum;
				ram_wdata = ram_rdata;
				state_d   = S_ROTF_ADV;
			end
			S_ROTF_ADV: begin
				ra_off  = CNT_W'(1);
				state_d = S_FRONT_RD;
			end
			S_ROTB_RD: begin
				// front already stepped back; the back entry sits one count beyond
				ra_off    = count_q;
				ram_raddr = ra_sum;
				state_d   = S_ROTB_WR;
			end
			S_ROTB_WR: begin
				ram_we    = 1'b1;
				ram_waddr = front_q;
				ram_wdata = ram_rdata;
				state_d   = S_FRONT_RD;
			end
			S_FRONT_RD: begin
				state_d = S_FRONT_WAIT;
			end
			S_FRONT_WAIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state: front, count, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_DISPATCH: begin
					case (req_q.op)
						OP_PUSH: begin
							if (!full) begin
								front_q <= ra_sum;
								count_q <= count_q + CNT_W'(1);
							end
						end
						OP_DELETE: begin
							if (!empty && !pos_bad && rem_calc == '0) begin
								count_q <= count_q - CNT_W'(1);
							end
						end
						OP_ROT_BACK: begin
							if (!empty) begin
								front_q <= ra_sum;
							end
						end
						OP_CLEAR: begin
							front_q <= '0;
							count_q <= '0;
						end
						default: begin
							front_q <= front_q;
						end
					endcase
				end
				S_DEL_WR: begin
					if (rem_q == CNT_W'(1)) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_ROTF_ADV: begin
					front_q <= ra_sum;
				end
				default: begin
					front_q <= front_q;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working registers and response word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req_word;
		end
		case (state_q)
			S_DISPATCH: begin
				slot_q <= ra_sum;
				rem_q  <= rem_calc;
				case (req_q.op)
					OP_PUSH: status_q <= full ? ST_FULL : ST_OK;
					OP_DELETE: status_q <= empty ? ST_EMPTY : (pos_bad ? ST_RANGE : ST_OK);
					OP_SWAP, OP_ROT_FWD, OP_ROT_BACK: status_q <= empty ? ST_EMPTY : ST_OK;
					default: status_q <= ST_OK;
				endcase
			end
			S_DEL_RD: begin
				nslot_q <= ra_sum;
			end
			S_DEL_WR: begin
				slot_q <= nslot_q;
				rem_q  <= rem_q - CNT_W'(1);
			end
			S_SWAP_RD1: begin
				tmp_q <= ram_rdata;
			end
			default: begin
				tmp_q <= tmp_q;
			end
		endcase
		if (rsp_load) begin
			rsp_q.front_value <= empty ? '0 : ram_rdata;
			rsp_q.entry_count <= 11'(count_q);
			rsp_q.status      <= status_q;
		end
	end

	`CDRS_ASSERT_IMPL(a_front_in_ring, clk, arst_n, 1'b1, 32'(front_q) < 32'(DEPTH), "front index outside the ring")
	`CDRS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, 32'(count_q) <= 32'(DEPTH), "entry count above depth")
	`CDRS_ASSERT_IMPL(a_del_moves_left, clk, arst_n, (state_q == S_DEL_RD) || (state_q == S_DEL_WR), rem_q != '0, "delete loop running with no moves left")
	`CDRS_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, req_valid && !req_stall, state_q == S_DISPATCH, "accepted word not dispatched")
	`CDRS_ASSERT_IMPL(a_rsp_from_wait, clk, arst_n, $rose(rsp_valid_q), $past(state_q) == S_FRONT_WAIT, "response raised outside front read")

endmodule

`default_nettype wire

@@ test/circular_deque_rotate_swap_tb.sv @@
// Self-checking testbench for the circular deque with push, delete, swap, rotate and clear.
`timescale 1ns / 1ps

module circular_deque_rotate_swap_tb;
	import cdrs_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CHURN_ITEMS = 25;
	localparam int FULL_ITEMS = 48;
	localparam int DRAIN_CYCLES = 32;
	localparam longint LIMIT_CYCLES = 64'd16_000_000;

	// op codes with no defined action; the block must answer them as no-ops
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	class deque_tracker;
		bit [31:0] slots [DEPTH];
		int unsigned front_slot;
		int unsigned held;
		int unsigned peak_held;
		rsp_t due[$];
		int unsigned checked;
		int unsigned faults;
		int unsigned status_seen [4];

		function int unsigned slot_of(int unsigned k);
			return (front_slot + k) % DEPTH;
		endfunction

		// Apply one accepted word to the shadow deque and queue the response it earns.
		function void note_request(req_t w);
			rsp_t r;
			int unsigned k;
			bit [31:0] keep;
			r.status = ST_OK;
			case (w.op)
				OP_PUSH: begin
					if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						front_slot = (front_slot + DEPTH - 1) % DEPTH;
						slots[front_slot] = w.value;
						held++;
					end
				end
				OP_DELETE: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else if (w.position >= held) begin
						r.status = ST_RANGE;
					end else begin
						// close the gap: later entries move one step toward the front
						for (k = w.position; k + 1 < held; k++)
							slots[slot_of(k)] = slots[slot_of(k + 1)];
						held--;
					end
				end
				OP_SWAP: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else if (held >= 2) begin
						keep = slots[slot_of(0)];
						slots[slot_of(0)] = slots[slot_of(1)];
						slots[slot_of(1)] = keep;
					end
				end
				OP_ROT_FWD: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						slots[slot_of(held)] = slots[front_slot];
						front_slot = slot_of(1);
					end
				end
				OP_ROT_BACK: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						front_slot = (front_slot + DEPTH - 1) % DEPTH;
						slots[front_slot] = slots[slot_of(held)];
					end
				end
				OP_CLEAR: begin
					held = 0;
					front_slot = 0;
				end
				default: begin
				end
			endcase
			r.front_value = (held != 0) ? slots[front_slot] : 32'd0;
			r.entry_count = 11'(held);
			if (held > peak_held)
				peak_held = held;
			status_seen[r.status]++;
			due.push_back(r);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected response word: front %0d count %0d status %0d",
						got.front_value, got.entry_count, got.status);
				return;
			end
			want = due.pop_front();
			checked++;
			if (got.front_value !== want.front_value || got.entry_count !== want.entry_count ||
					got.status !== want.status) begin
				faults++;
				if (faults <= 10)
					$display({"mismatch on response %0d: expected front %0d count %0d ",
						"status %0d, got front %0d count %0d status %0d"},
						checked, want.front_value, want.entry_count, want.status,
						got.front_value, got.entry_count, got.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_word;

	deque_tracker tracker = new();
	longint cycles = 0;
	int unsigned sent = 0;
	bit gapless = 1'b0;
	bit stall_quiet = 1'b0;
	int unsigned stall_run = 0;

	circular_deque_rotate_swap #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word(req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word(rsp_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function int unsigned pick_gap();
		int unsigned r;
		if ($urandom_range(0, 49) == 0)
			gapless = !gapless;
		if (gapless)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function int unsigned pick_stall_run();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(12, 40);
	endfunction

	// Receiver back-pressure: runs of stall, with quiet stretches that start no new stall.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_quiet = !stall_quiet;
		if (stall_run != 0) begin
			stall_run--;
		end else if (stall_quiet || $urandom_range(0, 99) < 55) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= 1'b1;
			stall_run = pick_stall_run();
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp_word);
	end

	function req_t word_of(logic [2:0] op, logic [31:0] value, logic [9:0] position);
		req_t w;
		w.op = op;
		w.value = value;
		w.position = position;
		return w;
	endfunction

	function logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Mostly live offsets, the rest anywhere in the field.
	function logic [9:0] pick_position();
		if (tracker.held != 0 && $urandom_range(0, 99) < 75)
			return 10'($urandom_range(0, tracker.held - 1));
		return 10'($urandom);
	endfunction

	function req_t build_word(logic [2:0] op);
		return word_of(op, pick_value(), pick_position());
	endfunction

	// Short deque: keep the count low so deletes stay cheap.
	function logic [2:0] pick_churn_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < ((tracker.held > 20) ? 18 : 34))
			return OP_PUSH;
		if (r < 58)
			return OP_DELETE;
		if (r < 68)
			return OP_SWAP;
		if (r < 80)
			return OP_ROT_FWD;
		if (r < 92)
			return OP_ROT_BACK;
		if (r < 96)
			return OP_CLEAR;
		if (r < 98)
			return OP_SPARE_LO;
		return OP_SPARE_HI;
	endfunction

	function logic [2:0] pick_fill_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 97)
			return OP_PUSH;
		if (r < 98)
			return OP_ROT_FWD;
		if (r < 99)
			return OP_ROT_BACK;
		return OP_SWAP;
	endfunction

	function logic [2:0] pick_full_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return OP_PUSH;
		if (r < 50)
			return OP_ROT_FWD;
		if (r < 70)
			return OP_ROT_BACK;
		if (r < 80)
			return OP_SWAP;
		return OP_DELETE;
	endfunction

	task send_word(input req_t w);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do
			@(posedge clk);
		while (req_stall);
		tracker.note_request(w);
		sent++;
	endtask

	// Hold the sender until every queued response has been taken.
	task drain_responses();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.due.size() != 0);
	endtask

	task run_churn();
		int n;
		for (n = 0; n < CHURN_ITEMS; n++) begin
			send_word(build_word(pick_churn_op()));
			if ($urandom_range(0, 99) == 0)
				drain_responses();
		end
	endtask

	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("circular_deque_rotate_swap regression: fail");
		$finish;
	end

	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque: everything but push is ignored or a no-op
		send_word(word_of(OP_DELETE, 32'h0, 10'd0));
		send_word(word_of(OP_SWAP, 32'h0, 10'd0));
		send_word(word_of(OP_ROT_FWD, 32'h0, 10'd0));
		send_word(word_of(OP_ROT_BACK, 32'h0, 10'd0));
		send_word(word_of(OP_CLEAR, 32'h0, 10'd0));
		send_word(word_of(OP_SPARE_LO, 32'hFFFF_FFFF, 10'h3FF));
		send_word(word_of(OP_SPARE_HI, 32'h0, 10'd0));
		// single entry: swap changes nothing, rotations come back to it
		send_word(word_of(OP_PUSH, 32'h7FFF_FFFF, 10'd0));
		send_word(word_of(OP_SWAP, 32'h0, 10'd0));
		send_word(word_of(OP_ROT_FWD, 32'h0, 10'd0));
		send_word(word_of(OP_ROT_BACK, 32'h0, 10'd0));
		send_word(word_of(OP_PUSH, 32'h8000_0000, 10'd0));
		send_word(word_of(OP_PUSH, 32'h0000_0000, 10'd0));
		send_word(word_of(OP_PUSH, 32'hFFFF_FFFF, 10'd0));
		send_word(word_of(OP_SWAP, 32'h0, 10'd0));
		send_word(word_of(OP_ROT_FWD, 32'h0, 10'd0));
		send_word(word_of(OP_ROT_BACK, 32'h0, 10'd0));
		// offsets at and past the count are rejected; live offsets then delete entries
		send_word(word_of(OP_DELETE, 32'h0, 10'h3FF));
		send_word(word_of(OP_DELETE, 32'h0, 10'd4));
		send_word(word_of(OP_DELETE, 32'h0, 10'd3));
		send_word(word_of(OP_DELETE, 32'h0, 10'd0));
		send_word(word_of(OP_DELETE, 32'h0, 10'd1));
		send_word(word_of(OP_DELETE, 32'h0, 10'd0));
		send_word(word_of(OP_PUSH, 32'h5A5A_A5A5, 10'd0));
		send_word(word_of(OP_CLEAR, 32'h0, 10'd0));
		drain_responses();

		run_churn();
		drain_responses();

		// fill to capacity, then work the deque at and near full
		while (tracker.held < DEPTH)
			send_word(build_word(pick_fill_op()));
		for (n = 0; n < FULL_ITEMS; n++)
			send_word(build_word(pick_full_op()));
		drain_responses();
		send_word(build_word(OP_CLEAR));

		run_churn();
		drain_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request words over %0d cycles, %0d responses checked, peak fill %0d of %0d",
			sent, cycles, tracker.checked, tracker.peak_held, DEPTH);
		$display("statuses seen: ok %0d, empty %0d, full %0d, offset out of range %0d",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_EMPTY],
			tracker.status_seen[ST_FULL], tracker.status_seen[ST_RANGE]);
		if (tracker.faults == 0 && tracker.due.size() == 0) begin
			$display("circular_deque_rotate_swap regression: pass");
		end else begin
			$display("%0d failures, %0d responses never arrived", tracker.faults,
				tracker.due.size());
			$display("circular_deque_rotate_swap regression: fail");
		end
		$finish;
	end

endmodule
